FILE: rtl/ewh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ewh_pkg;

   localparam int DATA_W      = 64;
   localparam int STEP_W      = $clog2(DATA_W);
   localparam int SEL_W       = 8;
   localparam int BINS_CFG_W  = 9;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOWEST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS   = 2'd2;

   localparam logic [BINS_CFG_W-1:0] BINS_RESET = 9'd256;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_MERGE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      BOP_ADD,
      BOP_READ,
      BOP_CLEAR
   } bin_op_type;

   typedef struct packed {
      logic       start;
      bin_op_type op;
   } bin_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bin_stat_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_WRITE
   } bins_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_BIN_GO,
      S_BIN_WAIT
   } top_state_type;

endpackage

`default_nettype wire

FILE: rtl/equal_width_histogram.sv
`timescale 1ns / 1ps
`default_nettype none

// Add sample: the serial divider finds the bin, then the counter is read and updated and the
// strobe follows; no new item is accepted until busy falls.
// Merge and read: the counter is read, then updated or returned, and the strobe follows.
// Clear all: one memory row per cycle, then the strobe.
// Reset: counters are swept to zero with busy high; registers reset.
// The receiver cannot stall: each result shows on rsp_* for one cycle with rsp_strobe.
module equal_width_histogram #(
   parameter int MAX_BINS    = 256,
   parameter int COUNT_WIDTH = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [ewh_pkg::DATA_W-1:0]          req_sample,
   input  wire logic [ewh_pkg::SEL_W-1:0]           req_bin_select,
   input  wire logic [ewh_pkg::DATA_W-1:0]          req_merge_count,
   output logic                                     rsp_strobe,
   output logic [ewh_pkg::SEL_W-1:0]                rsp_bin_touched,
   output logic [COUNT_WIDTH-1:0]                   rsp_bin_count,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ewh_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [ewh_pkg::DATA_W-1:0]          csr_data
);
   import ewh_pkg::*;

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam int N_W    = $clog2(MAX_BINS + 1);

   top_state_type          state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [DATA_W-1:0]      off_ff, off_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0] addend_ff, addend_in;
   logic [DATA_W-1:0]      low_ff, low_in;
   logic [DATA_W-1:0]      width_ff, width_in;
   logic [BINS_CFG_W-1:0]  bins_ff, bins_in;

   logic                   accept;
   mode_type               req_mode_e;
   logic [N_W-1:0]         active_n;
   logic [ADDR_W-1:0]      last_addr;
   logic [ADDR_W-1:0]      sel_addr;
   logic [ADDR_W-1:0]      q_addr;

   logic                   div_start;
   logic                   div_done;
   logic [DATA_W-1:0]      quotient;
   bin_cmd_type            bin_cmd;
   bin_stat_type           bin_stat;
   logic [COUNT_WIDTH-1:0] bin_count;

   ewh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_ff),
      .divisor  (width_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   ewh_bins #(
      .MAX_BINS    (MAX_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_bins (
      .clock      (clock),
      .reset      (reset),
      .cmd        (bin_cmd),
      .cmd_addr   (addr_ff),
      .cmd_addend (addend_ff),
      .stat       (bin_stat),
      .count      (bin_count)
   );

   assign busy       = (state_ff != S_IDLE) | bin_stat.busy;
   assign accept     = start & ~busy;
   assign req_mode_e = mode_type'(req_mode);
   assign csr_ready  = 1'b1;

   // bins in use: zero acts as one, above MAX_BINS acts as MAX_BINS
   always_comb begin
      if (bins_ff == '0) begin
         active_n = N_W'(1);
      end else if (32'(bins_ff) > 32'(MAX_BINS)) begin
         active_n = N_W'(MAX_BINS);
      end else begin
         active_n = N_W'(bins_ff);
      end
      last_addr = ADDR_W'(active_n - 1'b1);
      sel_addr  = (32'(req_bin_select) < 32'(active_n)) ? ADDR_W'(req_bin_select) : last_addr;
      q_addr    = (quotient < DATA_W'(active_n)) ? ADDR_W'(quotient) : last_addr;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      off_in      = off_ff;
      addr_in     = addr_ff;
      addend_in   = addend_ff;
      low_in      = low_ff;
      width_in    = width_ff;
      bins_in     = bins_ff;
      div_start   = 1'b0;
      bin_cmd.start = 1'b0;

      unique case (mode_ff) inside
         MODE_ADD, MODE_MERGE: bin_cmd.op = BOP_ADD;
         MODE_READ:            bin_cmd.op = BOP_READ;
         MODE_CLEAR:           bin_cmd.op = BOP_CLEAR;
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_LOWEST: low_in   = csr_data;
            CSR_WIDTH:  width_in = csr_data;
            CSR_BINS:   bins_in  = BINS_CFG_W'(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode_e;
               off_in  = req_sample - low_ff;
               addr_in = (req_mode_e == MODE_CLEAR) ? '0 : sel_addr;
               if (req_mode_e == MODE_ADD) begin
                  addend_in = COUNT_WIDTH'(1);
                  state_in  = S_DIV_GO;
               end else begin
                  addend_in = COUNT_WIDTH'(req_merge_count);
                  state_in  = S_BIN_GO;
               end
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               addr_in  = q_addr;
               state_in = S_BIN_GO;
            end
         end
         S_BIN_GO: begin
            bin_cmd.start = 1'b1;
            state_in      = S_BIN_WAIT;
         end
         S_BIN_WAIT: begin
            if (bin_stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_ADD;
         low_ff   <= '0;
         width_ff <= DATA_W'(1);
         bins_ff  <= BINS_RESET;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         low_ff   <= low_in;
         width_ff <= width_in;
         bins_ff  <= bins_in;
      end
      off_ff    <= off_in;
      addr_ff   <= addr_in;
      addend_ff <= addend_in;
   end

   assign rsp_strobe      = bin_stat.done;
   assign rsp_bin_touched = SEL_W'(addr_ff);
   assign rsp_bin_count   = bin_count;

   a_rsp_in_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == S_BIN_WAIT)
      else $error("result strobe outside of bin wait");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside of divide wait");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && mode_ff == MODE_CLEAR) |-> (rsp_bin_touched == '0 && rsp_bin_count == '0))
      else $error("clear item returned nonzero result");

endmodule

`default_nettype wire

FILE: rtl/ewh_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ewh_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ewh_pkg::DATA_W-1:0] dividend,
   input  wire logic [ewh_pkg::DATA_W-1:0] divisor,
   output logic                            done,
   output logic [ewh_pkg::DATA_W-1:0]      quotient
);
   import ewh_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] num_ff, num_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W+1:0] trial;
   logic              fits;

   // restoring division, one quotient bit per cycle; quotient shifts into num_ff
   // a zero divisor always fits, so it yields an all-ones quotient
   always_comb begin
      trial   = {1'b0, rem_ff, num_ff[DATA_W-1]} - {2'b00, den_ff};
      fits    = ~trial[DATA_W+1];
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? trial[DATA_W-1:0] : {rem_ff[DATA_W-2:0], num_ff[DATA_W-1]};
         num_in = {num_ff[DATA_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while running");

endmodule

`default_nettype wire

FILE: rtl/ewh_bins.sv
`timescale 1ns / 1ps
`default_nettype none

module ewh_bins #(
   parameter int MAX_BINS    = 256,
   parameter int COUNT_WIDTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ewh_pkg::bin_cmd_type         cmd,
   input  wire logic [$clog2(MAX_BINS)-1:0]  cmd_addr,
   input  wire logic [COUNT_WIDTH-1:0]       cmd_addend,
   output ewh_pkg::bin_stat_type             stat,
   output logic [COUNT_WIDTH-1:0]            count
);
   import ewh_pkg::*;

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BINS - 1);

   logic [COUNT_WIDTH-1:0] mem [MAX_BINS];

   bins_state_type         state_ff, state_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic                   rsp_ff, rsp_in;
   logic                   done_ff, done_in;
   bin_op_type             op_ff, op_in;
   logic [COUNT_WIDTH-1:0] addend_ff, addend_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic [COUNT_WIDTH-1:0] sum;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;

   always_comb begin
      sum       = rd_data_ff + addend_ff;
      state_in  = state_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      rsp_in    = rsp_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      addend_in = addend_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = sum;
      unique case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = B_IDLE;
               done_in  = rsp_ff;
               rsp_in   = 1'b0;
               count_in = '0;
            end
         end
         B_IDLE: begin
            if (cmd.start) begin
               addr_in   = cmd_addr;
               addend_in = cmd_addend;
               op_in     = cmd.op;
               if (cmd.op == BOP_CLEAR) begin
                  state_in = B_CLEAR;
                  clr_in   = '0;
                  rsp_in   = 1'b1;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            state_in = B_WRITE;
         end
         B_WRITE: begin
            state_in = B_IDLE;
            done_in  = 1'b1;
            if (op_ff == BOP_ADD) begin
               wr_en    = 1'b1;
               count_in = sum;
            end else begin
               count_in = rd_data_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         rsp_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_ff   <= rsp_in;
         done_ff  <= done_in;
      end
      addr_ff   <= addr_in;
      op_ff     <= op_in;
      addend_ff <= addend_in;
      count_ff  <= count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign stat.busy = (state_ff != B_IDLE);
   assign stat.done = done_ff;
   assign count     = count_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> state_ff == B_IDLE)
      else $error("bin update done while not idle");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_WRITE |-> $past(state_ff) == B_READ)
      else $error("bin write without preceding read");

endmodule

`default_nettype wire
